// ===== rtl/core/bsa_pkg.sv =====
package bsa_pkg;

	localparam int LAYERS_DEF    = 4;
	localparam int BATCHES_DEF   = 8;
	localparam int SLOTS_DEF     = 64;
	localparam int TEX_UNITS_DEF = 16;

	localparam logic [1:0] ST_TAKEN    = 2'd0;
	localparam logic [1:0] ST_RELEASED = 2'd1;
	localparam logic [1:0] ST_NO_BATCH = 2'd2;

	localparam logic MODE_TAKE    = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [1:0]  layer;
		logic [15:0] texture_id;
		logic [2:0]  batch_index;
		logic [5:0]  slot_index;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] taken_batch;
		logic [5:0] taken_slot;
		logic [3:0] tex_unit;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request, reset batch pointer
		logic rd_batch;  // read state of batch at pointer
		logic eval;      // evaluate read batch
		logic next;      // advance batch pointer
		logic activate;  // activate and clear first inactive batch, move pointer to it
		logic commit;    // write take into batch at pointer
		logic rel_rd;    // read binding of released slot
		logic rel_wr;    // apply release
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_release;
		logic layer_bad;
		logic ptr_last;
		logic batch_on;   // batch at pointer is active
		logic fits;       // evaluated batch fits
		logic any_free;   // layer has an inactive batch
	} dp_sts_t;

endpackage

// ===== rtl/core/batch_slot_allocator_with_tex_units_core.sv =====
// Batch slot allocator with reference-counted texture bindings.
// Input channel (in_valid/in_ready/in_data): one transaction is a take
// (mode 0) or a release (mode 1) for one layer. Output channel
// (out_valid/out_ready/out_data): exactly one result transaction per input.
// Config: cfg_we/cfg_data write active_tex_units; write only while idle.
// Steps from the accepting edge: a release passes decode (which reads the
// binding), a wait state and the write that emits its result; a take passes
// decode, a check of each batch visited, a read/evaluate/test of each active
// one, then the commit, with an activate followed by check and
// read/evaluate/test when a fresh batch is opened; when no batch is left the
// activate state ends it instead of the commit. The controller walks batches
// one at a time, reading one batch row of the binding memory per visit.
// One transaction is in flight at a time; a new one is taken only once the
// previous result has been handed off.
// Reset: all batches inactive, slot bitmaps clear, active_tex_units = 16;
// refcounts, slot bindings and texture ids stay unset. Refcounts are cleared
// on activation; the rest is only read behind a held slot or nonzero count.
// Stall: the result holds in the output register until out_ready.
module batch_slot_allocator_with_tex_units_core #(
	parameter int LAYERS    = bsa_pkg::LAYERS_DEF,
	parameter int BATCHES   = bsa_pkg::BATCHES_DEF,
	parameter int SLOTS     = bsa_pkg::SLOTS_DEF,
	parameter int TEX_UNITS = bsa_pkg::TEX_UNITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bsa_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output bsa_pkg::rsp_t out_data,
	input  logic          cfg_we,
	input  logic [4:0]    cfg_data
);
	import bsa_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	rsp_t    dp_rsp;

	bsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .dp_rsp(dp_rsp), .cmd(cmd), .out_data(out_data)
	);

	bsa_datapath #(
		.LAYERS(LAYERS), .BATCHES(BATCHES), .SLOTS(SLOTS), .TEX_UNITS(TEX_UNITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .req(in_data), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .sts(sts), .rsp(dp_rsp)
	);
endmodule

// ===== rtl/core/bsa_datapath.sv =====
module bsa_datapath #(
	parameter int LAYERS    = 4,
	parameter int BATCHES   = 8,
	parameter int SLOTS     = 64,
	parameter int TEX_UNITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bsa_pkg::req_t    req,
	input  bsa_pkg::dp_cmd_t cmd,
	input  logic             cfg_we,
	input  logic [4:0]       cfg_data,
	output bsa_pkg::dp_sts_t sts,
	output bsa_pkg::rsp_t    rsp
);
	import bsa_pkg::*;

	localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
	localparam int BW = (BATCHES > 1) ? $clog2(BATCHES) : 1;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int UW = (TEX_UNITS > 1) ? $clog2(TEX_UNITS) : 1;
	localparam int RW = $clog2(SLOTS + 1);
	localparam int NB = LAYERS * BATCHES;

	logic [4:0]          units_q;
	req_t                req_q;
	logic [BATCHES-1:0]  batch_active_q [LAYERS];
	logic [SLOTS-1:0]    slot_active_q [NB];
	logic [BW-1:0]       ptr_q;
	logic [LW-1:0]       lay;
	logic [LW+BW-1:0]    row;

	// binding memories: a tex/ref row holds all entries of a batch, bind_mem one entry per slot
	logic [TEX_UNITS*16-1:0] tex_mem [NB];
	logic [TEX_UNITS*RW-1:0] ref_mem [NB];
	logic [UW-1:0]           bind_mem [NB*SLOTS];

	logic [TEX_UNITS*16-1:0] tex_rd_q;
	logic [TEX_UNITS*RW-1:0] ref_rd_q;
	logic [SLOTS-1:0]        bits_rd_q;
	logic [UW-1:0]           bind_rd_q;
	logic                    fits_q;
	logic [SW-1:0]           slot_q;
	logic [UW-1:0]           unit_q;
	logic [TEX_UNITS-1:0]    refs_nz_q;

	assign lay = req_q.layer[LW-1:0];
	assign row = {lay, ptr_q};

	logic [5:0] n_units;
	always_comb begin
		n_units = {1'b0, units_q};
		if (units_q == 5'd0) n_units = 6'd1;
		if (n_units > 6'(TEX_UNITS)) n_units = 6'(TEX_UNITS);
	end

	// batch evaluation on registered row data
	logic              slot_found;
	logic [SW-1:0]     slot_sel;
	logic              hit_found, free_found;
	logic [UW-1:0]     hit_sel, free_sel;
	always_comb begin
		slot_found = 1'b0;
		slot_sel   = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (!bits_rd_q[s]) begin
				slot_found = 1'b1;
				slot_sel   = SW'(s);
			end
		end
		hit_found  = 1'b0;
		free_found = 1'b0;
		hit_sel    = '0;
		free_sel   = '0;
		for (int u = TEX_UNITS - 1; u >= 0; u--) begin
			if (6'(u) < n_units) begin
				if (ref_rd_q[u*RW +: RW] == '0) begin
					free_found = 1'b1;
					free_sel   = UW'(u);
				end else if (tex_rd_q[u*16 +: 16] == req_q.texture_id) begin
					hit_found = 1'b1;
					hit_sel   = UW'(u);
				end
			end
		end
	end

	logic [BW-1:0] free_batch;
	logic          any_free;
	always_comb begin
		any_free   = 1'b0;
		free_batch = '0;
		for (int b = BATCHES - 1; b >= 0; b--) begin
			if (!batch_active_q[lay][b]) begin
				any_free   = 1'b1;
				free_batch = BW'(b);
			end
		end
	end

	logic rel_ok;
	assign rel_ok = (32'(req_q.layer) < LAYERS) && (32'(req_q.batch_index) < BATCHES)
		&& (32'(req_q.slot_index) < SLOTS);
	logic [LW+BW-1:0] rel_row;
	assign rel_row = {lay, req_q.batch_index[BW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			units_q <= 5'd16;
			ptr_q   <= '0;
			fits_q  <= 1'b0;
			for (int l = 0; l < LAYERS; l++) batch_active_q[l] <= '0;
			for (int r = 0; r < NB; r++) slot_active_q[r] <= '0;
		end else begin
			if (cfg_we) units_q <= cfg_data;
			if (cmd.load) ptr_q <= '0;
			if (cmd.next) ptr_q <= ptr_q + BW'(1);
			if (cmd.eval) fits_q <= slot_found && (hit_found || free_found);
			if (cmd.activate) begin
				ptr_q <= free_batch;
				batch_active_q[lay][free_batch] <= 1'b1;
				slot_active_q[{lay, free_batch}] <= '0;
			end
			if (cmd.commit) slot_active_q[row][slot_q] <= 1'b1;
			if (cmd.rel_wr && rel_ok)
				slot_active_q[rel_row][req_q.slot_index[SW-1:0]] <= 1'b0;
		end
	end

	logic [TEX_UNITS*RW-1:0] ref_new;
	logic [TEX_UNITS*16-1:0] tex_new;
	always_comb begin
		ref_new = ref_rd_q;
		tex_new = tex_rd_q;
		ref_new[unit_q*RW +: RW] = ref_rd_q[unit_q*RW +: RW] + RW'(1);
		tex_new[unit_q*16 +: 16] = req_q.texture_id;
	end
	logic [TEX_UNITS*RW-1:0] ref_dec;
	always_comb begin
		ref_dec = ref_rd_q;
		if (ref_rd_q[bind_rd_q*RW +: RW] != '0)
			ref_dec[bind_rd_q*RW +: RW] = ref_rd_q[bind_rd_q*RW +: RW] - RW'(1);
	end

	// binding memories
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.rd_batch) begin
			tex_rd_q  <= tex_mem[row];
			ref_rd_q  <= ref_mem[row];
			bits_rd_q <= slot_active_q[row];
		end
		if (cmd.eval) begin
			slot_q <= slot_sel;
			unit_q <= hit_found ? hit_sel : free_sel;
		end
		if (cmd.activate) ref_mem[{lay, free_batch}] <= '0;
		if (cmd.commit) begin
			tex_mem[row] <= tex_new;
			ref_mem[row] <= ref_new;
			bind_mem[{row, slot_q}] <= unit_q;
		end
		if (cmd.rel_rd) begin
			ref_rd_q  <= ref_mem[rel_row];
			bits_rd_q <= slot_active_q[rel_row];
			bind_rd_q <= bind_mem[{rel_row, req_q.slot_index[SW-1:0]}];
		end
		if (cmd.rel_wr && rel_ok && bits_rd_q[req_q.slot_index[SW-1:0]])
			ref_mem[rel_row] <= ref_dec;
	end

	assign sts.is_release = (req_q.mode == MODE_RELEASE);
	assign sts.layer_bad  = (32'(req_q.layer) >= LAYERS);
	assign sts.ptr_last   = (32'(ptr_q) == BATCHES - 1);
	assign sts.batch_on   = batch_active_q[lay][ptr_q];
	assign sts.fits       = fits_q;
	assign sts.any_free   = any_free;

	assign rsp.status      = ST_TAKEN;
	assign rsp.taken_batch = 3'(ptr_q);
	assign rsp.taken_slot  = 6'(slot_q);
	assign rsp.tex_unit    = 4'(unit_q);
endmodule

// ===== rtl/core/bsa_ctrl.sv =====
module bsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  bsa_pkg::dp_sts_t sts,
	input  bsa_pkg::rsp_t    dp_rsp,
	output bsa_pkg::dp_cmd_t cmd,
	output bsa_pkg::rsp_t    out_data
);
	import bsa_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DEC    = 9'b000000010,
		S_CHK    = 9'b000000100,
		S_EVAL   = 9'b000001000,
		S_TEST   = 9'b000010000,
		S_ACT    = 9'b000100000,
		S_RELRD  = 9'b001000000,
		S_RELWR  = 9'b010000000,
		S_COMMIT = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   fresh_q, fresh_d;   // batch under test was just activated
	logic   ov_q;
	rsp_t   out_q;
	logic   emit;
	rsp_t   emit_rsp;

	assign in_ready  = (state_q == S_IDLE) && !ov_q;
	assign out_valid = ov_q;
	assign out_data  = out_q;

	always_comb begin
		state_d  = state_q;
		fresh_d  = fresh_q;
		cmd      = '0;
		emit     = 1'b0;
		emit_rsp = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				fresh_d = 1'b0;
				if (sts.is_release) begin
					cmd.rel_rd = 1'b1;
					state_d    = S_RELRD;
				end else if (sts.layer_bad) begin
					emit            = 1'b1;
					emit_rsp.status = ST_NO_BATCH;
					state_d         = S_IDLE;
				end else begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.batch_on) begin
					cmd.rd_batch = 1'b1;
					state_d      = S_EVAL;
				end else if (sts.ptr_last) begin
					state_d = S_ACT;
				end else begin
					cmd.next = 1'b1;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_TEST;
			end
			S_TEST: begin
				if (sts.fits) begin
					state_d = S_COMMIT;
				end else if (fresh_q) begin
					emit            = 1'b1;
					emit_rsp.status = ST_NO_BATCH;
					state_d         = S_IDLE;
				end else if (sts.ptr_last) begin
					state_d = S_ACT;
				end else begin
					cmd.next = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_ACT: begin
				if (sts.any_free) begin
					cmd.activate = 1'b1;
					fresh_d      = 1'b1;
					state_d      = S_CHK;
				end else begin
					emit            = 1'b1;
					emit_rsp.status = ST_NO_BATCH;
					state_d         = S_IDLE;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				emit       = 1'b1;
				emit_rsp   = dp_rsp;
				state_d    = S_IDLE;
			end
			S_RELRD: state_d = S_RELWR;
			S_RELWR: begin
				cmd.rel_wr      = 1'b1;
				emit            = 1'b1;
				emit_rsp.status = ST_RELEASED;
				state_d         = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fresh_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			fresh_q <= fresh_d;
			if (emit) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= emit_rsp;
	end
endmodule

// ===== rtl/core/bsa_checker.sv =====
module bsa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input bsa_pkg::rsp_t out_data
);
	import bsa_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped under stall");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result without processing");

	a_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3)
		else $error("bad status");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_TAKEN |->
		out_data.taken_batch == 3'd0 && out_data.taken_slot == 6'd0
		&& out_data.tex_unit == 4'd0)
		else $error("nonzero fields on non-take result");
endmodule

bind batch_slot_allocator_with_tex_units_core bsa_checker u_bsa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== sim/tb_top.sv =====
module tb_top;
	import bsa_pkg::*;

	localparam int NL = LAYERS_DEF;
	localparam int NB = BATCHES_DEF;
	localparam int NS = SLOTS_DEF;
	localparam int NT = TEX_UNITS_DEF;
	localparam int CYCLE_LIMIT = 900000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;
	logic cfg_we = 1'b0;
	logic [4:0] cfg_data = '0;

	always #5 clk = ~clk;

	batch_slot_allocator_with_tex_units_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// Shadow copy of the allocator state.
	logic [4:0]  tex_units_reg;
	logic [NB-1:0] batch_on [NL];
	logic [NS-1:0] slot_held [NL][NB];
	logic [3:0]  slot_unit [NL][NB][NS];
	logic [15:0] unit_tex [NL][NB][NT];
	int          unit_refs [NL][NB][NT];

	rsp_t expected_rsp[$];
	int   mismatches = 0;
	int   cycles = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   hold_off = 0;   // receiver hold-off cycles left

	// Pool of held slots so releases mostly hit live slots.
	logic [10:0] held_pool[$];

	function automatic int usable_units();
		int n;
		n = int'(tex_units_reg);
		if (n == 0) n = 1;
		if (n > NT) n = NT;
		return n;
	endfunction

	function automatic bit try_take(int l, int b, logic [15:0] tex, output rsp_t r);
		int s, u, fs, fu;
		r = '0;
		r.status = ST_NO_BATCH;
		fs = -1; fu = -1;
		for (s = 0; s < NS; s++)
			if (!slot_held[l][b][s] && fs < 0) fs = s;
		if (fs < 0) return 0;
		for (u = 0; u < usable_units(); u++) begin
			if (unit_refs[l][b][u] == 0) begin
				if (fu < 0) fu = u;
			end else if (unit_tex[l][b][u] == tex) begin
				fu = u;
				break;
			end
		end
		if (fu < 0) return 0;
		slot_held[l][b][fs] = 1'b1;
		unit_tex[l][b][fu] = tex;
		unit_refs[l][b][fu]++;
		slot_unit[l][b][fs] = fu[3:0];
		r = '0;
		r.status = ST_TAKEN;
		r.taken_batch = b[2:0];
		r.taken_slot = fs[5:0];
		r.tex_unit = fu[3:0];
		held_pool.push_back({l[1:0], b[2:0], fs[5:0]});
		return 1;
	endfunction

	function automatic rsp_t predict_alloc(req_t q);
		rsp_t r;
		int l, b, s, u;
		r = '0;
		l = int'(q.layer); b = int'(q.batch_index); s = int'(q.slot_index);
		if (q.mode == MODE_RELEASE) begin
			r.status = ST_RELEASED;
			if (slot_held[l][b][s]) begin
				u = int'(slot_unit[l][b][s]);
				slot_held[l][b][s] = 1'b0;
				if (unit_refs[l][b][u] != 0) unit_refs[l][b][u]--;
			end
			return r;
		end
		r.status = ST_NO_BATCH;
		for (b = 0; b < NB; b++)
			if (batch_on[l][b] && try_take(l, b, q.texture_id, r)) return r;
		for (b = 0; b < NB; b++)
			if (!batch_on[l][b]) begin
				batch_on[l][b] = 1'b1;
				slot_held[l][b] = '0;
				for (u = 0; u < NT; u++) begin
					unit_refs[l][b][u] = 0;
					unit_tex[l][b][u] = '0;
				end
				for (s = 0; s < NS; s++) slot_unit[l][b][s] = '0;
				if (!try_take(l, b, q.texture_id, r)) r.status = ST_NO_BATCH;
				return r;
			end
		return r;
	endfunction

	// Send one transaction; the prediction is queued at acceptance.
	task automatic send_req(req_t q);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
			@(posedge clk);
		in_valid <= 1'b1;
		in_data <= q;
		do @(posedge clk); while (!in_ready);
		expected_rsp.push_back(predict_alloc(q));
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic take(int l, logic [15:0] tex);
		req_t q;
		q = '0;
		q.mode = MODE_TAKE; q.layer = l[1:0]; q.texture_id = tex;
		q.batch_index = 3'($urandom); q.slot_index = 6'($urandom);
		send_req(q);
	endtask

	task automatic release_slot(int l, int b, int s);
		req_t q;
		q = '0;
		q.mode = MODE_RELEASE; q.layer = l[1:0]; q.batch_index = b[2:0];
		q.slot_index = s[5:0]; q.texture_id = 16'($urandom);
		send_req(q);
	endtask

	task automatic release_held();
		int i;
		logic [10:0] e;
		if (held_pool.size() == 0) return;
		i = $urandom_range(held_pool.size() - 1);
		e = held_pool[i];
		held_pool.delete(i);
		release_slot(int'(e[10:9]), int'(e[8:6]), int'(e[5:0]));
	endtask

	// Drain, settle, then write the register while idle.
	task automatic set_tex_units(logic [4:0] v);
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tex_units_reg = v;
	endtask

	// Receiver and result checker.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction %p", out_data);
			end else begin
				rsp_t e;
				e = expected_rsp.pop_front();
				if (out_data.status !== e.status || out_data.taken_batch !== e.taken_batch
						|| out_data.taken_slot !== e.taken_slot
						|| out_data.tex_unit !== e.tex_unit) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", e, out_data);
				end
			end
		end
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Directed: extreme ids and indices, a shared binding, releases, all 16 units of a batch.
	task automatic test_directed();
		int i;
		take(0, 16'h0000);
		take(0, 16'hFFFF);
		take(0, 16'hFFFF);        // shares an existing binding
		take(3, 16'hA5A5);
		release_slot(0, 0, 1);    // held slot
		release_slot(0, 0, 1);    // slot no longer held
		release_slot(0, 7, 63);   // batch never activated
		release_slot(3, 0, 0);
		release_slot(2, 5, 17);
		for (i = 0; i < 16; i++) take(1, 16'h0100 + i[15:0]);
	endtask

	// Fewest units: every new texture opens a batch until none is left.
	task automatic test_units_min();
		int i;
		set_tex_units(5'd1);
		for (i = 0; i < 10; i++) take(2, 16'h2000 + i[15:0]);
		set_tex_units(5'd0);
		take(2, 16'h2000);
		take(2, 16'h3333);
	endtask

	// Fill a whole layer of slots so takes run out of batches.
	task automatic test_fill_layer();
		int i;
		set_tex_units(5'd31);
		for (i = 0; i < NB * NS + 4; i++) take(3, 16'h0042);
		for (i = 0; i < 6; i++) release_held();
		for (i = 0; i < 6; i++) take(3, 16'h0042);
	endtask

	// Long receiver hold-off while the sender keeps offering.
	task automatic test_backpressure();
		int i;
		hold_off = 300;
		for (i = 0; i < 20; i++) take(0, 16'($urandom_range(3)));
	endtask

	task automatic random_phase(int n, int s_pct, int r_pct);
		int i, k;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 50) take($urandom_range(3), 16'($urandom_range(24)));
			else if (k < 60) take($urandom_range(3), 16'($urandom));
			else if (k < 90) release_held();
			else release_slot($urandom_range(3), $urandom_range(7), $urandom_range(63));
		end
	endtask

	task automatic test_random();
		set_tex_units(5'd4);
		random_phase(460, 28, 52);
		set_tex_units(5'd16);
		random_phase(460, 52, 28);
		set_tex_units(5'd2);
		random_phase(445, 0, 0);
	endtask

	initial begin
		int l, b;
		tex_units_reg = 5'd16;
		for (l = 0; l < NL; l++) begin
			batch_on[l] = '0;
			for (b = 0; b < NB; b++) slot_held[l][b] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_units_min();
		test_fill_layer();
		test_random();
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== batch_slot_allocator_with_tex_units_core.f =====
rtl/core/bsa_pkg.sv
rtl/core/bsa_datapath.sv
rtl/core/bsa_ctrl.sv
rtl/core/batch_slot_allocator_with_tex_units_core.sv
rtl/core/bsa_checker.sv
sim/tb_top.sv
